>>> sv/upd_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helper functions of the url percent decoder
package upd_pkg;

  localparam logic [7:0] ByteC3     = 8'hC3;
  localparam logic [7:0] ChPct      = 8'h25;
  localparam logic [7:0] ChUscore   = 8'h5F;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned QCw    = $clog2(QDepth + 1);

  // decoder phase
  typedef enum logic [2:0] {
    PH_PLAIN = 3'd0,
    PH_HIGH1 = 3'd1,
    PH_LOW1  = 3'd2,
    PH_HOLD  = 3'd3,
    PH_HIGH2 = 3'd4,
    PH_LOW2  = 3'd5
  } phase_e;

  // what the back end has to put out for one queued command
  typedef enum logic [1:0] {
    CMD_ONE  = 2'd0,  // one byte
    CMD_PAIR = 2'd1,  // held 0xc3, then one byte
    CMD_MARK = 2'd2   // bare end marker
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] ch;
    logic       last;
  } cmd_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      v = c[3:0] + 4'd9;
    return v;
  endfunction

  function automatic logic [7:0] map_second(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      8'h84:   r = 8'hC4;
      8'h96:   r = 8'hD6;
      8'h9C:   r = 8'hDC;
      8'h9F:   r = 8'hDF;
      8'hA4:   r = 8'hE4;
      8'hB6:   r = 8'hF6;
      8'hBC:   r = 8'hFC;
      default: r = ChUscore;
    endcase
    return r;
  endfunction

endpackage

>>> sv/url_percent_decoder_latin1.sv
`timescale 1ns / 1ps
// top level of the url percent decoder with utf-8 to latin-1 umlaut mapping
// a result passes through the command queue and then the output register before it appears
// throughput: one character per cycle unless the queue is full; results leave one per
//   cycle while the output is ready; a held 0xc3 plus next byte takes two output items
// the four-entry command queue between front and back end absorbs those extra items
// reset: asynchronous, active low; clears phase, queue pointers and output valid
module url_percent_decoder_latin1 (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input characters
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_char
  input  logic       s_axis_tlast_i,   // in_last
  // decoded bytes
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_char
  output logic       m_axis_tuser_o,   // [0] char_valid
  output logic       m_axis_tlast_o    // out_last
);
  import upd_pkg::*;

  // front to queue
  logic push;
  cmd_t cmd;
  logic q_full;
  // queue to back
  logic head_valid;
  cmd_t head;
  logic pop;

  // front: phase machine, one character per cycle, stalls only on a full queue
  upd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_char_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .q_full_i   (q_full),
    .in_ready_o (s_axis_tready_o),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  // commands waiting for the output side
  upd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // back: expands each command into one or two output items
  upd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_char_o   (m_axis_tdata_o),
    .char_valid_o (m_axis_tuser_o),
    .out_last_o   (m_axis_tlast_o)
  );

endmodule

>>> sv/upd_front.sv
`timescale 1ns / 1ps
// front end: accepts characters, runs the escape phase machine, issues commands
module upd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    in_char_i,
  input  logic          in_last_i,
  input  logic          q_full_i,
  output logic          in_ready_o,
  output logic          push_o,
  output upd_pkg::cmd_t cmd_o
);
  import upd_pkg::*;

  phase_e     phase_q, phase_d;
  logic [3:0] nib_q, nib_d;
  logic       fire;
  logic [3:0] hex_c;
  logic [7:0] byte_c;

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && !q_full_i;
  assign hex_c      = hex_value(in_char_i);
  assign byte_c     = {nib_q, hex_c};

  // next state
  always_comb begin
    phase_d = phase_q;
    nib_d   = nib_q;
    if (fire) begin
      unique case (phase_q)
        PH_HIGH1: begin
          nib_d   = hex_c;
          phase_d = PH_LOW1;
        end
        PH_LOW1:  phase_d = (byte_c == ByteC3) ? PH_HOLD : PH_PLAIN;
        PH_HOLD:  phase_d = (in_char_i == ChPct) ? PH_HIGH2 : PH_PLAIN;
        PH_HIGH2: begin
          nib_d   = hex_c;
          phase_d = PH_LOW2;
        end
        PH_LOW2:  phase_d = PH_PLAIN;
        default:  phase_d = (in_char_i == ChPct) ? PH_HIGH1 : PH_PLAIN;
      endcase
      if (in_last_i) begin
        phase_d = PH_PLAIN;
        nib_d   = 4'd0;
      end
    end
  end

  // command issue
  always_comb begin
    push_o      = 1'b0;
    cmd_o.kind  = CMD_ONE;
    cmd_o.ch    = in_char_i;
    cmd_o.last  = in_last_i;
    unique case (phase_q)
      PH_HIGH1: begin
        push_o     = fire && in_last_i;
        cmd_o.kind = CMD_MARK;
        cmd_o.ch   = 8'd0;
      end
      PH_LOW1: begin
        push_o   = fire && ((byte_c != ByteC3) || in_last_i);
        cmd_o.ch = byte_c;
      end
      PH_HOLD: begin
        if (in_char_i == ChPct) begin
          push_o   = fire && in_last_i;
          cmd_o.ch = ByteC3;
        end else begin
          push_o     = fire;
          cmd_o.kind = CMD_PAIR;
        end
      end
      PH_HIGH2: begin
        push_o   = fire && in_last_i;
        cmd_o.ch = ByteC3;
      end
      PH_LOW2: begin
        push_o   = fire;
        cmd_o.ch = map_second(byte_c);
      end
      default: begin
        if (in_char_i == ChPct) begin
          push_o     = fire && in_last_i;
          cmd_o.kind = CMD_MARK;
          cmd_o.ch   = 8'd0;
        end else begin
          push_o = fire;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PLAIN;
      nib_q   <= 4'd0;
    end else begin
      phase_q <= phase_d;
      nib_q   <= nib_d;
    end
  end

endmodule

>>> sv/upd_queue.sv
`timescale 1ns / 1ps
// small command queue between front and back end
module upd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  upd_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          head_valid_o,
  output upd_pkg::cmd_t head_o
);
  import upd_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QAw-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QCw-1:0]   cnt_q, cnt_d;
  logic             do_pop;

  assign full_o       = (cnt_q == QCw'(QDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + QCw'(push_i) - QCw'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> sv/upd_back.sv
`timescale 1ns / 1ps
// back end: expands queued commands into result items in an output register
module upd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  upd_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_char_o,
  output logic          char_valid_o,
  output logic          out_last_o
);
  import upd_pkg::*;

  logic       vld_q, vld_d;
  logic       second_q, second_d;
  logic [7:0] ch_q, ch_d;
  logic       cv_q, cv_d;
  logic       last_q, last_d;
  logic       load;

  assign load = head_valid_i && (!vld_q || out_ready_i);

  always_comb begin
    vld_d    = vld_q && !out_ready_i;
    second_d = second_q;
    ch_d     = ch_q;
    cv_d     = cv_q;
    last_d   = last_q;
    pop_o    = 1'b0;
    if (load) begin
      vld_d = 1'b1;
      unique case (head_i.kind)
        CMD_PAIR: begin
          if (!second_q) begin
            ch_d     = ByteC3;
            cv_d     = 1'b1;
            last_d   = 1'b0;
            second_d = 1'b1;
          end else begin
            ch_d     = head_i.ch;
            cv_d     = 1'b1;
            last_d   = head_i.last;
            second_d = 1'b0;
            pop_o    = 1'b1;
          end
        end
        CMD_MARK: begin
          ch_d   = 8'd0;
          cv_d   = 1'b0;
          last_d = 1'b1;
          pop_o  = 1'b1;
        end
        default: begin
          ch_d   = head_i.ch;
          cv_d   = 1'b1;
          last_d = head_i.last;
          pop_o  = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= 1'b0;
      second_q <= 1'b0;
    end else begin
      vld_q    <= vld_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    cv_q   <= cv_d;
    last_q <= last_d;
  end

  assign out_valid_o  = vld_q;
  assign out_char_o   = ch_q;
  assign char_valid_o = cv_q;
  assign out_last_o   = last_q;

endmodule
